@@ rtl/exact_fit_region_allocator_defines.svh @@
// Assertion macros used by the allocator datapath RTL.
`ifndef EXACT_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define EXACT_FIT_REGION_ALLOCATOR_DEFINES_SVH

// Checks that a condition holds at every clock edge out of reset.
`define EFRA_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("allocator check failed");

// Checks that a condition in the next cycle follows from a condition now.
`define EFRA_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ rtl/efra_pkg.sv @@
// Shared types and constants of the exact-fit region allocator.
package efra_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam logic [DATA_W-1:0] CAP_RESET = 16'hFFFF;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MV_RD,
    ST_MV_WR,
    ST_BUMP,
    ST_REL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_cur;
    logic rd_next;
    logic take;
    logic idx_inc;
    logic mv_write;
    logic bump;
    logic release_op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_rel;
    logic count_zero;
    logic match;
    logic scan_last;
    logic mv_more;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/efra_ctrl.sv @@
// Controller state machine of the exact-fit region allocator.
module efra_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  efra_pkg::sts_t  sts,
  output efra_pkg::cmd_t  cmd
);

  efra_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == efra_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      efra_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = efra_pkg::ST_DECODE;
        end
      end
      efra_pkg::ST_DECODE: begin
        if (sts.req_rel) begin
          state_nxt = efra_pkg::ST_REL;
        end else if (sts.count_zero) begin
          state_nxt = efra_pkg::ST_BUMP;
        end else begin
          state_nxt = efra_pkg::ST_SCAN_RD;
        end
      end
      efra_pkg::ST_SCAN_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = efra_pkg::ST_SCAN_CMP;
      end
      efra_pkg::ST_SCAN_CMP: begin
        if (sts.match) begin
          cmd.take  = 1'b1;
          state_nxt = efra_pkg::ST_MV_RD;
        end else if (sts.scan_last) begin
          state_nxt = efra_pkg::ST_BUMP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = efra_pkg::ST_SCAN_RD;
        end
      end
      efra_pkg::ST_MV_RD: begin
        if (sts.mv_more) begin
          cmd.rd_next = 1'b1;
          state_nxt   = efra_pkg::ST_MV_WR;
        end else begin
          state_nxt = efra_pkg::ST_FIN;
        end
      end
      efra_pkg::ST_MV_WR: begin
        cmd.mv_write = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = efra_pkg::ST_MV_RD;
      end
      efra_pkg::ST_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = efra_pkg::ST_FIN;
      end
      efra_pkg::ST_REL: begin
        cmd.release_op = 1'b1;
        state_nxt      = efra_pkg::ST_FIN;
      end
      efra_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = efra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = efra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/efra_dpath.sv @@
// Datapath of the exact-fit region allocator: registers, free-list memory and result register.
`include "exact_fit_region_allocator_defines.svh"

module efra_dpath #(
  parameter int unsigned FREE_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [efra_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic [efra_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [efra_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  efra_pkg::cmd_t                    cmd,
  output efra_pkg::sts_t                    sts
);

  localparam int unsigned IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(FREE_SLOTS + 1);
  localparam int unsigned SUM_W = efra_pkg::DATA_W + CNT_W;
  localparam int unsigned DW    = efra_pkg::DATA_W;

  logic [DW-1:0]    cap_r;
  logic [DW-1:0]    bump_r;
  logic [CNT_W-1:0] count_r;
  logic [SUM_W-1:0] sum_r;
  logic [IDX_W-1:0] idx_r;
  logic             req_r;
  logic [DW-1:0]    size_r;
  logic [DW-1:0]    offset_r;
  logic             valid_r;
  logic             granted_r;
  logic [DW-1:0]    goff_r;
  logic             ovf_r;
  logic             out_valid_r;
  logic [efra_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [2*DW-1:0]  mem [FREE_SLOTS];
  logic [2*DW-1:0]  rd_r;

  logic             full;
  logic             rel_write;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [2*DW-1:0]  wr_data;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_p1;
  logic             tail_fit;
  logic [DW-1:0]    tail;
  logic [SUM_W:0]   free_sum;
  logic [DW-1:0]    free_total;

  assign full      = (count_r == CNT_W'(FREE_SLOTS));
  assign rel_write = cmd.release_op && valid_r && !full;
  assign mem_we    = rel_write || cmd.mv_write;
  assign wr_addr   = cmd.mv_write ? idx_r : count_r[IDX_W-1:0];
  assign wr_data   = cmd.mv_write ? rd_r : {offset_r, size_r};
  assign rd_addr   = cmd.rd_next ? IDX_W'(idx_r + IDX_W'(1)) : idx_r;
  assign idx_ext   = CNT_W'(idx_r);
  assign idx_p1    = idx_ext + CNT_W'(1);

  assign tail_fit   = (cap_r >= bump_r) && (size_r <= (cap_r - bump_r));
  assign tail       = (cap_r > bump_r) ? (cap_r - bump_r) : '0;
  assign free_sum   = (SUM_W+1)'(tail) + (SUM_W+1)'(sum_r);
  assign free_total = (free_sum > (SUM_W+1)'(16'hFFFF)) ? 16'hFFFF : free_sum[DW-1:0];

  assign sts.req_rel    = (req_r == efra_pkg::REQ_RELEASE);
  assign sts.count_zero = (count_r == '0);
  assign sts.match      = (rd_r[DW-1:0] == size_r);
  assign sts.scan_last  = (idx_p1 >= count_r);
  assign sts.mv_more    = (idx_ext < count_r);
  assign sts.out_busy   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_cur || cmd.rd_next) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= efra_pkg::CAP_RESET;
      bump_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.take) begin
        count_r <= count_r - CNT_W'(1);
        sum_r   <= sum_r - SUM_W'(size_r);
      end else if (rel_write) begin
        count_r <= count_r + CNT_W'(1);
        sum_r   <= sum_r + SUM_W'(size_r);
      end
      if (cmd.bump && tail_fit) begin
        bump_r <= bump_r + size_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_tuser;
      size_r    <= in_tdata[15:0];
      offset_r  <= in_tdata[31:16];
      valid_r   <= in_tdata[32];
      idx_r     <= '0;
      granted_r <= 1'b0;
      goff_r    <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.take) begin
        granted_r <= 1'b1;
        goff_r    <= rd_r[2*DW-1:DW];
      end
      if (cmd.bump && tail_fit) begin
        granted_r <= 1'b1;
        goff_r    <= bump_r;
      end
      if (cmd.release_op && valid_r && full) begin
        ovf_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_data_r <= {6'b0, ovf_r, free_total, granted_r, goff_r};
    end
  end

  `EFRA_CHECK(a_count_max, count_r <= CNT_W'(FREE_SLOTS))
  `EFRA_CHECK_NEXT(a_take_dec, cmd.take, count_r == $past(count_r) - CNT_W'(1))
  `EFRA_CHECK_NEXT(a_rel_full, cmd.release_op && valid_r && full, ovf_r && full)
  `EFRA_CHECK(a_out_excl, !(out_valid_r && out_data_r[16] && out_data_r[33]))

endmodule

@@ rtl/exact_fit_region_allocator.sv @@
// Top level of the exact-fit region allocator.
// Allocates regions of a buffer of cfg-programmed capacity from an exact-fit
// free list of FREE_SLOTS entries, falling back to bump allocation, and releases
// regions by appending them to that list. One request is worked at a time. A
// release passes through the decode, release and finish states. An allocation
// scans the listed holes in order and, on a hit, compacts the list behind it;
// the free list lives in a single-port memory with a registered read, visited
// once per entry for the scan and twice per entry for the compaction. The next
// request is accepted while a finished result still waits on the output.
module exact_fit_region_allocator #(
  parameter int unsigned FREE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // total_capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,     // region_size, region_offset, region_valid
  input  logic        in_tuser,     // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata     // granted_offset, granted, free_total, list_overflow
);

  efra_pkg::cmd_t cmd;
  efra_pkg::sts_t sts;

  efra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  efra_dpath #(
    .FREE_SLOTS (FREE_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ verif/efra_alloc_sb_pkg.sv @@
// Scoreboard package for the exact-fit region allocator testbench.
package efra_alloc_sb_pkg;
  import efra_pkg::*;

  localparam int unsigned HOLE_SLOTS = 16;

  typedef struct packed {
    logic        list_overflow;
    logic [15:0] free_total;
    logic        granted;
    logic [15:0] granted_offset;
  } grant_t;

  class alloc_ledger;
    logic [15:0] capacity;
    logic [15:0] bump;
    logic [15:0] hole_off[HOLE_SLOTS];
    logic [15:0] hole_sz[HOLE_SLOTS];
    int unsigned hole_cnt;
    int unsigned hole_sum;
    grant_t      expected_grants[$];
    int unsigned errors;
    int unsigned grants;
    int unsigned hole_hits;
    int unsigned refusals;
    int unsigned appends;
    int unsigned overflows;

    function new();
      capacity  = CAP_RESET;
      bump      = '0;
      hole_cnt  = 0;
      hole_sum  = 0;
      errors    = 0;
      grants    = 0;
      hole_hits = 0;
      refusals  = 0;
      appends   = 0;
      overflows = 0;
    endfunction

    function void set_capacity(logic [15:0] value);
      capacity = value;
    endfunction

    function int unsigned tail_space();
      if (capacity > bump) begin
        return int'(capacity) - int'(bump);
      end
      return 0;
    endfunction

    function int unsigned hole_count();
      return hole_cnt;
    endfunction

    function logic [15:0] listed_size(int unsigned idx);
      return hole_sz[idx];
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction

    function grant_t book_request(logic req, logic [15:0] size, logic [15:0] offset,
                                  logic valid);
      grant_t      res;
      bit          hit;
      int unsigned i;
      int unsigned j;
      int unsigned free_sum;
      res = '0;
      hit = 1'b0;
      if (req == REQ_ALLOC) begin
        for (i = 0; i < hole_cnt; i++) begin
          if (hole_sz[i] == size) begin
            hit = 1'b1;
            res.granted = 1'b1;
            res.granted_offset = hole_off[i];
            hole_sum = hole_sum - size;
            for (j = i; j + 1 < hole_cnt; j++) begin
              hole_off[j] = hole_off[j+1];
              hole_sz[j]  = hole_sz[j+1];
            end
            hole_cnt--;
            hole_hits++;
            break;
          end
        end
        if (!hit && capacity >= bump && size <= tail_space()) begin
          res.granted = 1'b1;
          res.granted_offset = bump;
          bump = bump + size;
        end
        if (res.granted) begin
          grants++;
        end else begin
          refusals++;
        end
      end else if (valid) begin
        if (hole_cnt < HOLE_SLOTS) begin
          hole_off[hole_cnt] = offset;
          hole_sz[hole_cnt]  = size;
          hole_cnt++;
          hole_sum = hole_sum + size;
          appends++;
        end else begin
          res.list_overflow = 1'b1;
          overflows++;
        end
      end
      free_sum = tail_space() + hole_sum;
      res.free_total = (free_sum > 32'hFFFF) ? 16'hFFFF : free_sum[15:0];
      expected_grants.insert(expected_grants.size(), res);
      return res;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) begin
        $display("mismatch: %s", msg);
      end
    endtask

    task match_result(logic [39:0] beat);
      grant_t got;
      grant_t want;
      got = beat[33:0];
      if (expected_grants.size() == 0) begin
        report($sformatf("result beat %h arrived with nothing expected", beat));
        return;
      end
      want = expected_grants.pop_front();
      if (got.granted_offset !== want.granted_offset) begin
        report($sformatf("granted_offset got %h want %h", got.granted_offset,
                         want.granted_offset));
      end
      if (got.granted !== want.granted) begin
        report($sformatf("granted got %b want %b", got.granted, want.granted));
      end
      if (got.free_total !== want.free_total) begin
        report($sformatf("free_total got %h want %h", got.free_total, want.free_total));
      end
      if (got.list_overflow !== want.list_overflow) begin
        report($sformatf("list_overflow got %b want %b", got.list_overflow,
                         want.list_overflow));
      end
    endtask
  endclass

endpackage

@@ verif/tb_exact_fit_region_allocator.sv @@
// Testbench top for the exact-fit region allocator.
module tb_exact_fit_region_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import efra_pkg::*;
  import efra_alloc_sb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * HOLE_SLOTS + 8;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned NUM_PHASES   = 7;

  typedef struct {
    logic [15:0] off;
    logic [15:0] size;
  } region_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  alloc_ledger ledger;
  region_t     live_regions[$];
  int unsigned cycle_count = 0;
  int unsigned sent_items  = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_left  = 0;

  exact_fit_region_allocator #(
    .FREE_SLOTS (HOLE_SLOTS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 7) != 0);
      end
      default: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      ledger.match_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_exact_fit_region_allocator: FAIL");
      $finish;
    end
  end

  task send_beat(logic req, logic [15:0] size, logic [15:0] offset, logic valid);
    grant_t  res;
    region_t rgn;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'b0, valid, offset, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = ledger.book_request(req, size, offset, valid);
    if (req == REQ_ALLOC && res.granted) begin
      rgn.off  = res.granted_offset;
      rgn.size = size;
      live_regions.insert(live_regions.size(), rgn);
    end
    sent_items++;
  endtask

  task pause(int unsigned cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task wait_drained();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_capacity(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.set_capacity(value);
    cfg_we <= 1'b0;
  endtask

  task paced_beat(logic req, logic [15:0] size, logic [15:0] offset, logic valid);
    send_beat(req, size, offset, valid);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 29) == 0) begin
        wait_drained();
      end else if ($urandom_range(0, 2) != 0) begin
        pause($urandom_range(1, 10));
      end
    end
  endtask

  task random_request();
    int unsigned pick;
    int unsigned sel;
    int unsigned idx;
    logic [15:0] size;
    region_t     rgn;
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 80 && live_regions.size() == 0)) begin
      sel = $urandom_range(0, 19);
      if (sel < 9 && ledger.hole_count() > 0) begin
        size = ledger.listed_size($urandom_range(0, ledger.hole_count() - 1));
      end else if (sel < 15) begin
        size = 16'($urandom_range(0, 63));
      end else if (sel < 18) begin
        size = 16'($urandom_range(0, 1023));
      end else begin
        size = 16'($urandom_range(0, 65535));
      end
      paced_beat(REQ_ALLOC, size, 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
    end else if (pick < 80) begin
      idx = $urandom_range(0, live_regions.size() - 1);
      rgn = live_regions[idx];
      live_regions.delete(idx);
      paced_beat(REQ_RELEASE, rgn.size, rgn.off, 1'b1);
    end else if (pick < 90) begin
      paced_beat(REQ_RELEASE, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 1'b0);
    end else begin
      size = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                  : 16'($urandom_range(0, 255));
      paced_beat(REQ_RELEASE, size, 16'($urandom_range(0, 65535)), 1'b1);
    end
  endtask

  initial begin
    logic [15:0] phase_caps[NUM_PHASES];
    int unsigned start_count;
    int unsigned p;
    int unsigned k;
    ledger = new();
    phase_caps[0] = 16'd777;
    phase_caps[1] = 16'd0;
    phase_caps[2] = 16'd4096;
    phase_caps[3] = 16'hFFFF;
    phase_caps[4] = 16'($urandom_range(0, 65535));
    phase_caps[5] = 16'd1;
    phase_caps[6] = 16'hFFFF;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_capacity(16'hFFFF);

    paced_beat(REQ_ALLOC, 16'd0, 16'd0, 1'b0);
    paced_beat(REQ_ALLOC, 16'd100, 16'hFFFF, 1'b1);
    paced_beat(REQ_ALLOC, 16'hFFFF, 16'd0, 1'b0);
    paced_beat(REQ_RELEASE, 16'hFFFF, 16'hFFFF, 1'b0);
    paced_beat(REQ_RELEASE, 16'd0, 16'd7, 1'b1);
    paced_beat(REQ_RELEASE, 16'hFFFF, 16'hFFFF, 1'b1);
    for (k = 1; k <= HOLE_SLOTS - 2; k++) begin
      paced_beat(REQ_RELEASE, k[15:0], 16'(k * 16), 1'b1);
    end
    paced_beat(REQ_RELEASE, 16'd5, 16'd500, 1'b1);
    paced_beat(REQ_ALLOC, 16'd0, 16'd0, 1'b0);
    paced_beat(REQ_ALLOC, 16'hFFFF, 16'd0, 1'b0);
    wait_drained();

    // The capacity now sits below the bump pointer, so only listed holes can be granted.
    write_capacity(16'd50);
    paced_beat(REQ_ALLOC, 16'd20, 16'd0, 1'b0);
    paced_beat(REQ_ALLOC, 16'd5, 16'd0, 1'b0);
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      start_count = sent_items;
      while (sent_items - start_count < RANDOM_ITEMS / NUM_PHASES) begin
        random_request();
      end
      wait_drained();
    end

    $display("Sent %0d requests over %0d capacity settings: %0d grants, %0d from the free list,",
             sent_items, NUM_PHASES + 2, ledger.grants, ledger.hole_hits);
    $display("%0d refused allocations, %0d releases listed and %0d dropped on a full list.",
             ledger.refusals, ledger.appends, ledger.overflows);
    if (ledger.errors == 0) begin
      $display("tb_exact_fit_region_allocator: PASS");
    end else begin
      $display("tb_exact_fit_region_allocator: FAIL");
    end
    $finish;
  end

endmodule
